// ----- rtl/cht_pkg.sv -----
// Constants and derived widths for the chained hash table.
package cht_pkg;

    localparam int NUM_BUCKETS  = 10;
    localparam int BUCKET_DEPTH = 32;

    localparam int KEY_W   = 16;
    localparam int CMP_W   = 6;
    localparam int TOTAL_W = 9;

    localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W  = $clog2(NUM_BUCKETS * BUCKET_DEPTH);
    localparam int CNT_W   = $clog2(NUM_BUCKETS * BUCKET_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;

    // key / NUM_BUCKETS as (key * RECIP) >> RECIP_SHIFT, exact over the key range
    localparam int RECIP_SHIFT = KEY_W + BKT_W;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + NUM_BUCKETS - 1) / NUM_BUCKETS;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = KEY_W + RECIP_W;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

// ----- rtl/chained_hash_table.sv -----
// Chained hash table: bucket hash, key memory and the insert / search sequencer.
//
//  channel   dir  signals                       contents
//  s_        in   tvalid tready tdata tuser     tdata: key; tuser: action
//  m_        out  tvalid tready tdata           tdata: found, comparisons, rejected,
//                                               total_entries
//
// An insert passes through ST_MUL, ST_MOD, ST_INS and ST_PUT from transfer to result; a
// search walks ST_SRCH in place of ST_INS for k comparisons (at most BUCKET_DEPTH), as the
// key memory gives one entry per cycle. ST_MUL and ST_MOD form the reciprocal-multiply bucket hash.
// Reset clears the bucket fill counts and entry count; key memory needs no clearing.
// A new item is taken while a result waits on m_; a held result stalls only the next.
module chained_hash_table
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cht_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] key
    input  logic                           s_tuser,   // [0] action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cht_pkg::OUT_DATA_W-1:0] m_tdata    // [0] found, [6:1] comparisons,
                                                      // [7] rejected, [16:8] total_entries
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_MUL  = 3'd1;
    localparam logic [ST_W-1:0] ST_MOD  = 3'd2;
    localparam logic [ST_W-1:0] ST_INS  = 3'd3;
    localparam logic [ST_W-1:0] ST_SRCH = 3'd4;
    localparam logic [ST_W-1:0] ST_PUT  = 3'd5;

    localparam logic [cht_pkg::FILL_W-1:0] FILL_FULL =
        cht_pkg::FILL_W'(cht_pkg::BUCKET_DEPTH);

    logic [ST_W-1:0]               state_reg, state_next;
    logic                          action_reg;
    logic [cht_pkg::KEY_W-1:0]     key_reg;
    logic [cht_pkg::KEY_W-1:0]     quot_reg;
    logic [cht_pkg::BKT_W-1:0]     bucket_reg;
    logic [cht_pkg::FILL_W-1:0]    fill_reg [cht_pkg::NUM_BUCKETS];
    logic [cht_pkg::CNT_W-1:0]     cnt_reg;
    logic [cht_pkg::FILL_W-1:0]    idx_reg;
    logic [cht_pkg::FILL_W-1:0]    cmps_reg;
    logic                          rd_valid_reg;
    logic [cht_pkg::KEY_W-1:0]     rdata_reg;
    logic                          res_found_reg;
    logic                          res_rej_reg;
    logic                          m_valid_reg;
    logic [cht_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic [cht_pkg::KEY_W-1:0]     mem [cht_pkg::MEM_DEPTH];

    logic [cht_pkg::PROD_W-1:0]    prod;
    logic [cht_pkg::BKT_W-1:0]     bucket_calc;
    logic [cht_pkg::FILL_W-1:0]    fill_cur;
    logic [cht_pkg::ADDR_W-1:0]    base_addr;
    logic [cht_pkg::ADDR_W-1:0]    mem_addr;
    logic                          s_xfer;
    logic                          out_free;
    logic                          rd_en;
    logic                          wr_en;
    logic                          hit;
    logic                          srch_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // bucket = key - floor(key / N) * N
    assign prod        = cht_pkg::PROD_W'(key_reg) *
                         cht_pkg::PROD_W'(cht_pkg::RECIP);
    assign bucket_calc = cht_pkg::BKT_W'(key_reg -
                         cht_pkg::KEY_W'(quot_reg * cht_pkg::KEY_W'(cht_pkg::NUM_BUCKETS)));

    assign fill_cur  = fill_reg[bucket_reg];
    assign base_addr = cht_pkg::ADDR_W'(bucket_reg) *
                       cht_pkg::ADDR_W'(cht_pkg::BUCKET_DEPTH);
    assign mem_addr  = base_addr + cht_pkg::ADDR_W'((state_reg == ST_INS) ? fill_cur : idx_reg);

    assign wr_en     = (state_reg == ST_INS) && (fill_cur != FILL_FULL);
    assign rd_en     = (state_reg == ST_SRCH) && (idx_reg < fill_cur);
    assign hit       = rd_valid_reg && (rdata_reg == key_reg);
    // every issued read has been compared once idx reaches the fill
    assign srch_done = hit || (idx_reg == fill_cur);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_xfer) state_next = ST_MUL;
            ST_MUL:  state_next = ST_MOD;
            ST_MOD:  state_next = (action_reg == cht_pkg::ACT_SEARCH) ? ST_SRCH : ST_INS;
            ST_INS:  state_next = ST_PUT;
            ST_SRCH: if (srch_done) state_next = ST_PUT;
            ST_PUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int b = 0; b < cht_pkg::NUM_BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (wr_en)
            begin
                fill_reg[bucket_reg] <= fill_cur + 1'b1;
                cnt_reg              <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_PUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            action_reg <= s_tuser;
            key_reg    <= s_tdata[cht_pkg::KEY_W-1:0];
        end
        if (state_reg == ST_MUL)
            quot_reg <= cht_pkg::KEY_W'(prod >> cht_pkg::RECIP_SHIFT);
        if (state_reg == ST_MOD)
        begin
            bucket_reg    <= bucket_calc;
            idx_reg       <= '0;
            cmps_reg      <= '0;
            res_found_reg <= 1'b0;
            res_rej_reg   <= 1'b0;
        end
        if (state_reg == ST_INS)
            res_rej_reg <= !wr_en;
        if (state_reg == ST_SRCH)
        begin
            if (rd_en)
                idx_reg <= idx_reg + 1'b1;
            if (rd_valid_reg)
                cmps_reg <= cmps_reg + 1'b1;
            res_found_reg <= hit;
        end
        if (state_reg == ST_PUT && out_free)
        begin
            m_data_reg <= {{(cht_pkg::OUT_DATA_W - cht_pkg::TOTAL_W - cht_pkg::CMP_W - 2){1'b0}},
                           cht_pkg::TOTAL_W'(cnt_reg),
                           res_rej_reg,
                           cht_pkg::CMP_W'(cmps_reg),
                           res_found_reg};
        end
    end

    // key memory: one write or one read per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[mem_addr] <= key_reg;
        if (rd_en)
            rdata_reg <= mem[mem_addr];
    end

    a_srch_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |-> (idx_reg <= fill_cur))
        else $error("search index ran past the bucket fill");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cht_pkg::CNT_W'(cht_pkg::MEM_DEPTH))
        else $error("entry count beyond table capacity");

    a_full_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS && fill_cur == FILL_FULL) |=> res_rej_reg)
        else $error("insert into a full bucket not rejected");

    a_found_rej_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[7]))
        else $error("result both found and rejected");

endmodule

// ----- test/chained_hash_table_test.sv -----
// Self-checking testbench for the chained hash table: directed table, then random traffic.
module chained_hash_table_test;
    import cht_pkg::*;

    localparam int RANDOM_ITEMS = 1530;
    localparam int WATCHDOG     = 2000;
    localparam int TAIL_CYCLES  = 60;

    typedef struct packed {
        logic               found;
        logic [CMP_W-1:0]   comparisons;
        logic               rejected;
        logic [TOTAL_W-1:0] total_entries;
    } lookup_t;

    typedef struct packed {
        logic             act;
        logic [KEY_W-1:0] key;
        logic             typed;
        lookup_t          exp;
    } row_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = ACT_INSERT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    chained_hash_table uut
    (
        .clk,
        .rst_n,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .s_tuser,
        .m_tvalid,
        .m_tready,
        .m_tdata
    );

    // Shadow table
    logic [KEY_W-1:0] chain [NUM_BUCKETS][BUCKET_DEPTH];
    int unsigned      chain_len [NUM_BUCKETS] = '{default: 0};
    int unsigned      stored = 0;

    lookup_t          pending [$];
    logic [KEY_W-1:0] pool [$];
    bit               steady = 1'b0;
    int               errors = 0;
    int               idle_cycles = 0;
    int               n_ins = 0, n_rej = 0, n_srch = 0, n_hit = 0, deepest = 0;

    // Directed rows; expectations typed in only where obvious
    row_t plan [0:17] = '{
        {ACT_SEARCH, 16'd0,     1'b1, 1'b0, 6'd0, 1'b0, 9'd0},  // empty table
        {ACT_SEARCH, 16'd65535, 1'b1, 1'b0, 6'd0, 1'b0, 9'd0},
        {ACT_INSERT, 16'd0,     1'b1, 1'b0, 6'd0, 1'b0, 9'd1},
        {ACT_INSERT, 16'd65535, 1'b1, 1'b0, 6'd0, 1'b0, 9'd2},
        {ACT_INSERT, 16'd65535, 1'b1, 1'b0, 6'd0, 1'b0, 9'd3},  // duplicate kept
        {ACT_SEARCH, 16'd65535, 1'b0, 17'd0},
        {ACT_SEARCH, 16'd65525, 1'b0, 17'd0},                   // miss, same bucket
        {ACT_INSERT, 16'd10,    1'b0, 17'd0},
        {ACT_SEARCH, 16'd10,    1'b0, 17'd0},
        {ACT_SEARCH, 16'd0,     1'b0, 17'd0},
        {ACT_SEARCH, 16'd20,    1'b0, 17'd0},
        {ACT_INSERT, 16'd32768, 1'b0, 17'd0},
        {ACT_SEARCH, 16'd32768, 1'b0, 17'd0},
        {ACT_INSERT, 16'd21845, 1'b0, 17'd0},
        {ACT_INSERT, 16'd43690, 1'b0, 17'd0},
        {ACT_SEARCH, 16'd43690, 1'b0, 17'd0},
        {ACT_SEARCH, 16'd21845, 1'b0, 17'd0},
        {ACT_SEARCH, 16'd1,     1'b0, 17'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic lookup_t apply_op(input logic act, input logic [KEY_W-1:0] key);
        lookup_t     r;
        int unsigned b;
        b = key % NUM_BUCKETS;
        r = '0;
        if (act == ACT_INSERT)
        begin
            if (chain_len[b] >= BUCKET_DEPTH)
                r.rejected = 1'b1;
            else
            begin
                chain[b][chain_len[b]] = key;
                chain_len[b]++;
                stored++;
            end
        end
        else
        begin
            for (int i = 0; i < chain_len[b]; i++)
            begin
                r.comparisons++;
                if (chain[b][i] == key)
                begin
                    r.found = 1'b1;
                    break;
                end
            end
        end
        r.total_entries = stored[TOTAL_W-1:0];
        return r;
    endfunction

    // Offer one item, wait for the transfer, then log what it should produce
    task automatic run_item(input logic act, input logic [KEY_W-1:0] key,
                            input logic typed, input lookup_t typed_exp);
        int      gap;
        lookup_t got;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= key;
        do @(posedge clk); while (!s_tready);
        got = apply_op(act, key);
        pending.push_back(typed ? typed_exp : got);
        if (act == ACT_INSERT)
        begin
            n_ins++;
            if (got.rejected)
                n_rej++;
            else
                pool.push_back(key);
        end
        else
        begin
            n_srch++;
            if (got.found)
                n_hit++;
            if (got.comparisons > deepest)
                deepest = got.comparisons;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        lookup_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected result transfer: tdata %h", d);
            errors++;
        end
        else
        begin
            want = pending.pop_front();
            if (d[0] !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, d[0]);
                errors++;
            end
            if (d[CMP_W:1] !== want.comparisons)
            begin
                $error("comparisons: expected %0d, got %0d", want.comparisons, d[CMP_W:1]);
                errors++;
            end
            if (d[CMP_W+1] !== want.rejected)
            begin
                $error("rejected: expected %0d, got %0d", want.rejected, d[CMP_W+1]);
                errors++;
            end
            if (d[CMP_W+2 +: TOTAL_W] !== want.total_entries)
            begin
                $error("total_entries: expected %0d, got %0d",
                       want.total_entries, d[CMP_W+2 +: TOTAL_W]);
                errors++;
            end
            if (d[OUT_DATA_W-1:CMP_W+2+TOTAL_W] !== '0)
            begin
                $error("padding: expected 0, got %h", d[OUT_DATA_W-1:CMP_W+2+TOTAL_W]);
                errors++;
            end
        end
    endtask

    // Result side: random back-pressure per transfer
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("no transfer for %0d cycles", WATCHDOG);
            $display("FAIL chained_hash_table");
            $finish;
        end
    end

    initial
    begin
        logic             act;
        logic [KEY_W-1:0] key;
        int               hot;
        hot = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            run_item(plan[i].act, plan[i].key, plan[i].typed, plan[i].exp);
        drain();

        // Mostly keys already stored or aimed at one bucket, so chains fill up
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n % 100 == 0)
                hot = $urandom_range(0, NUM_BUCKETS - 1);
            if (n % 400 == 399)
                drain();
            act = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: key = (pool.size() != 0) ? pool[$urandom_range(0, pool.size() - 1)]
                                                     : KEY_W'($urandom);
                4, 5, 6:    key = KEY_W'(NUM_BUCKETS * $urandom_range(0, 6552) + hot);
                default:    key = KEY_W'($urandom);
            endcase
            run_item(act, key, 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d inserts (%0d refused on a full bucket) and %0d searches",
                 n_ins, n_rej, n_srch);
        $display("(%0d hits, longest walk %0d comparisons); %0d keys stored at the end.",
                 n_hit, deepest, stored);
        if (errors == 0)
            $display("PASS chained_hash_table");
        else
            $display("FAIL chained_hash_table");
        $finish;
    end

endmodule
